// File: design/codel_pkg.sv
`default_nettype none

package codel_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int REG_W      = 16;
  localparam int BYTES_W    = 24;
  localparam int CNT_W      = 16;
  localparam int SQ_W       = 32;
  localparam int ROOT_W     = 16;
  localparam int REM_W      = ROOT_W + 1;
  localparam int SU_W       = ROOT_W + 2;
  localparam int DIV_STEPS  = SQ_W;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int ITER_W     = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_DELAY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_INTERVAL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_PACKET_BYTES = 2'd2;

  localparam logic [REG_W-1:0] TARGET_DELAY_RST     = 16'd5;
  localparam logic [REG_W-1:0] DROP_INTERVAL_RST    = 16'd100;
  localparam logic [REG_W-1:0] ONE_PACKET_BYTES_RST = 16'd1504;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_LOOP  = 2'd1,
    PH_ENTRY = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_JUDGE,
    S_DIV,
    S_SQRT,
    S_ADD,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

// File: design/codel_drop_controller.sv
// CoDel drop controller, decision path only.
// Input channel (in_valid/in_ready): one beat per head packet removed from the queue,
// carrying start_of_call, current_time, arrival_stamp, queue_empty_after and bytes_after.
// Output channel (out_valid/out_ready): one beat per input beat with drop and
// fetch_another, which are equal; a dropped packet always asks for another fetch.
// Configuration channel (cfg_valid/cfg_ready): index 0 target_delay, 1 drop_interval,
// 2 one_packet_bytes; writes are always taken, other indexes are ignored.
// A packet that needs no new drop time passes the prep and judge steps to the final step.
// A packet that needs one (entering dropping mode, or a further drop decision inside
// a call) also passes the divide, square root and add steps: a shared 18-bit subtract
// and compare unit runs 32 restoring divide steps for interval squared over the drop
// count and then 16 square root steps, one step per cycle. The block takes one packet
// at a time; it is ready again as soon as the result is registered. A finished result
// waits in the output register while the next packet is accepted; if the receiver
// stalls, the following result holds in the last step until the output register is
// free. Reset loads the register defaults (5, 100, 1504), clears all controller state
// and leaves the block ready.
`default_nettype none

module codel_drop_controller #(
  parameter int TIME_BITS = 48
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [codel_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [codel_pkg::REG_W-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             start_of_call,
  input  logic [TIME_BITS-1:0]             current_time,
  input  logic [TIME_BITS-1:0]             arrival_stamp,
  input  logic                             queue_empty_after,
  input  logic [codel_pkg::BYTES_W-1:0]   bytes_after,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             drop,
  output logic                             fetch_another
);
  import codel_pkg::*;

  state_t state, state_next;

  logic [REG_W-1:0] target_delay, drop_interval, one_packet_bytes;

  logic [TIME_BITS-1:0] first_above, next_drop_time;
  logic [CNT_W-1:0]     drop_count, last_drop_count;
  logic                 in_dropping;
  phase_t               call_phase;

  logic [TIME_BITS-1:0] now_r, arr_r, sojourn;
  logic                 empty_r;
  logic [BYTES_W-1:0]   bytes_r;
  phase_t               phase_r;
  logic [SQ_W-1:0]      sq;
  logic                 drop_r, base_now, via_div;
  logic [CNT_W-1:0]     divisor;
  logic [SQ_W-1:0]      quo;
  logic [REM_W-1:0]     rem;
  logic [ROOT_W-1:0]    root;
  logic [ITER_W-1:0]    iter;

  logic                 quiet, fa_unset, ok, need_div, fin_go, drop_fin;
  logic [CNT_W-1:0]     delta, entry_count;
  logic [TIME_BITS-1:0] since;

  logic [SU_W-1:0]      su_a, su_b, su_diff;
  logic                 su_borrow, su_ge;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_delay     <= TARGET_DELAY_RST;
      drop_interval    <= DROP_INTERVAL_RST;
      one_packet_bytes <= ONE_PACKET_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET_DELAY:     target_delay     <= cfg_data;
        REG_DROP_INTERVAL:    drop_interval    <= cfg_data;
        REG_ONE_PACKET_BYTES: one_packet_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decision terms, valid while the judge step runs on the latched packet.
  assign quiet = empty_r || (sojourn < TIME_BITS'(target_delay)) ||
                 (bytes_r <= BYTES_W'(one_packet_bytes));
  assign fa_unset = (first_above == '0);
  assign ok = !quiet && !fa_unset && (now_r >= first_above);
  assign delta = drop_count - last_drop_count;
  assign since = now_r - next_drop_time;
  assign entry_count = (delta > CNT_W'(1) &&
                        since < TIME_BITS'({drop_interval, 4'b0000})) ? delta : CNT_W'(1);
  assign need_div = (phase_r == PH_ENTRY) || (phase_r == PH_LOOP && ok);

  assign fin_go = (state == S_FIN) && (!out_valid || out_ready);
  assign drop_fin = (via_div && phase_r == PH_LOOP) ?
                    (in_dropping && now_r >= next_drop_time) : drop_r;

  // Shared subtract and compare unit for the divide and square root steps.
  always_comb begin
    case (state)
      S_DIV: begin
        su_a = {1'b0, rem[ROOT_W-1:0], quo[SQ_W-1]};
        su_b = SU_W'(divisor);
      end
      S_SQRT: begin
        su_a = {rem[ROOT_W-1:0], quo[SQ_W-1:SQ_W-2]};
        su_b = {root, 2'b01};
      end
      default: begin
        su_a = '0;
        su_b = '0;
      end
    endcase
    {su_borrow, su_diff} = {1'b0, su_a} - {1'b0, su_b};
    su_ge = !su_borrow;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_PREP;
        end
      end
      S_PREP: state_next = S_JUDGE;
      S_JUDGE: state_next = need_div ? S_DIV : S_FIN;
      S_DIV: begin
        if (iter == ITER_W'(DIV_STEPS - 1)) begin
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        if (iter == ITER_W'(SQRT_STEPS - 1)) begin
          state_next = S_ADD;
        end
      end
      S_ADD: state_next = S_FIN;
      S_FIN: begin
        if (fin_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          now_r   <= current_time;
          arr_r   <= arrival_stamp;
          empty_r <= queue_empty_after;
          bytes_r <= bytes_after;
          phase_r <= start_of_call ? PH_FIRST : call_phase;
        end
      end
      S_PREP: begin
        sojourn <= now_r - arr_r;
        sq      <= SQ_W'(drop_interval) * SQ_W'(drop_interval);
      end
      S_JUDGE: begin
        via_div  <= need_div;
        base_now <= (phase_r == PH_ENTRY);
        quo      <= sq;
        rem      <= '0;
        iter     <= '0;
        divisor  <= (phase_r == PH_ENTRY) ? entry_count :
                    ((drop_count == '0) ? CNT_W'(1) : drop_count);
        case (phase_r)
          PH_ENTRY, PH_LOOP: drop_r <= 1'b0;
          default: begin
            if (in_dropping) begin
              drop_r <= ok && (now_r >= next_drop_time);
            end else begin
              drop_r <= ok;
              if (ok) begin
                phase_r <= PH_ENTRY;
              end
            end
          end
        endcase
      end
      S_DIV: begin
        quo <= {quo[SQ_W-2:0], su_ge};
        if (iter == ITER_W'(DIV_STEPS - 1)) begin
          rem  <= '0;
          root <= '0;
          iter <= '0;
        end else begin
          rem  <= su_ge ? su_diff[REM_W-1:0] : su_a[REM_W-1:0];
          iter <= iter + ITER_W'(1);
        end
      end
      S_SQRT: begin
        quo  <= {quo[SQ_W-3:0], 2'b00};
        root <= {root[ROOT_W-2:0], su_ge};
        rem  <= su_ge ? su_diff[REM_W-1:0] : su_a[REM_W-1:0];
        iter <= iter + ITER_W'(1);
      end
      default: ;
    endcase
  end

  // Controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_above     <= '0;
      next_drop_time  <= '0;
      drop_count      <= '0;
      last_drop_count <= '0;
      in_dropping     <= 1'b0;
      call_phase      <= PH_FIRST;
    end else begin
      case (state)
        S_JUDGE: begin
          if (quiet) begin
            first_above <= '0;
          end else if (fa_unset) begin
            first_above <= now_r + TIME_BITS'(drop_interval);
          end
          case (phase_r)
            PH_ENTRY: begin
              in_dropping     <= 1'b1;
              drop_count      <= entry_count;
              last_drop_count <= entry_count;
            end
            default: begin
              if (!ok) begin
                in_dropping <= 1'b0;
              end
            end
          endcase
        end
        S_ADD: begin
          next_drop_time <= (base_now ? now_r : next_drop_time) + TIME_BITS'(root);
        end
        S_FIN: begin
          if (fin_go) begin
            if (drop_fin && phase_r != PH_ENTRY) begin
              if (drop_count != CNT_MAX) begin
                drop_count <= drop_count + CNT_W'(1);
              end
              call_phase <= PH_LOOP;
            end else if (!drop_fin) begin
              call_phase <= PH_FIRST;
            end else begin
              call_phase <= PH_ENTRY;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      drop          <= drop_fin;
      fetch_another <= drop_fin;
    end
  end

  // The count only grows from the value recorded on entry to dropping mode.
  a_count_order: assert property (@(posedge clk) disable iff (rst)
    drop_count >= last_drop_count)
    else $error("drop count fell below the count recorded on entry");

  // A further drop inside a call is only possible while in dropping mode.
  a_loop_dropping: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && call_phase == PH_LOOP) |-> in_dropping)
    else $error("loop phase pending outside dropping mode");

  // The entry drop is only taken when not yet in dropping mode.
  a_entry_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && call_phase == PH_ENTRY) |-> !in_dropping)
    else $error("entry phase pending while already in dropping mode");

  // The divider never starts with a zero divisor.
  a_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (divisor != '0))
    else $error("control law divide started with a zero count");

endmodule

`default_nettype wire

// File: tb/codel_drop_controller_tb.sv
`timescale 1ns / 100ps

module codel_drop_controller_tb;
  import codel_pkg::*;

  localparam int TIME_W = 48;
  localparam logic [TIME_W-1:0] T_MAX = '1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic                start;
    logic [TIME_W-1:0]   now;
    logic [TIME_W-1:0]   arr;
    logic                empty;
    logic [BYTES_W-1:0]  bytes;
  } pkt_t;

  typedef struct packed {
    logic drop;
    logic fetch;
  } verdict_t;

  // Tracks the controller state and the verdicts still owed by the block.
  class codel_law_tracker;
    logic [REG_W-1:0]  target;
    logic [REG_W-1:0]  interval;
    logic [REG_W-1:0]  min_bytes;
    logic [TIME_W-1:0] first_above;
    logic [TIME_W-1:0] next_drop;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  last_count;
    bit                dropping;
    phase_t            phase;
    verdict_t          pending[$];
    bit                last_drop;
    int                errors;

    function new();
      target      = TARGET_DELAY_RST;
      interval    = DROP_INTERVAL_RST;
      min_bytes   = ONE_PACKET_BYTES_RST;
      first_above = '0;
      next_drop   = '0;
      count       = '0;
      last_count  = '0;
      dropping    = 1'b0;
      phase       = PH_FIRST;
      last_drop   = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      case (idx)
        REG_TARGET_DELAY: target = val;
        REG_DROP_INTERVAL: interval = val;
        REG_ONE_PACKET_BYTES: min_bytes = val;
        default: ;
      endcase
    endfunction

    function logic [ROOT_W-1:0] floor_root(logic [31:0] x);
      logic [ROOT_W-1:0] r;
      logic [ROOT_W-1:0] trial;
      r = '0;
      for (int i = ROOT_W - 1; i >= 0; i--) begin
        trial = r | (ROOT_W'(1) << i);
        if (64'(trial) * 64'(trial) <= 64'(x)) r = trial;
      end
      return r;
    endfunction

    function logic [TIME_W-1:0] law_step(logic [TIME_W-1:0] t, logic [CNT_W-1:0] c);
      logic [31:0] sq;
      logic [31:0] div;
      div = (c == '0) ? 32'd1 : 32'(c);
      sq = 32'(interval) * 32'(interval);
      return t + TIME_W'(floor_root(sq / div));
    endfunction

    function bit sojourn_bad(pkt_t p);
      logic [TIME_W-1:0] soj;
      if (p.empty) begin
        first_above = '0;
        return 1'b0;
      end
      soj = p.now - p.arr;
      if (soj < TIME_W'(target) || p.bytes <= BYTES_W'(min_bytes)) begin
        first_above = '0;
        return 1'b0;
      end
      if (first_above == '0) begin
        first_above = p.now + TIME_W'(interval);
        return 1'b0;
      end
      return p.now >= first_above;
    endfunction

    function void take_packet(pkt_t p);
      phase_t            ph;
      bit                ok;
      bit                drp;
      logic [CNT_W-1:0]  delta;
      logic [TIME_W-1:0] since;
      ph = p.start ? PH_FIRST : phase;
      ok = sojourn_bad(p);
      drp = 1'b0;
      if (ph == PH_ENTRY) begin
        delta = count - last_count;
        since = p.now - next_drop;
        dropping = 1'b1;
        count = (delta > 1 && since < (TIME_W'(interval) << 4)) ? delta : CNT_W'(1);
        next_drop = law_step(p.now, count);
        last_count = count;
      end else if (ph == PH_LOOP) begin
        if (ok) next_drop = law_step(next_drop, count);
        else dropping = 1'b0;
        drp = dropping && p.now >= next_drop;
      end else if (dropping) begin
        if (!ok) dropping = 1'b0;
        drp = dropping && p.now >= next_drop;
      end else if (ok) begin
        drp = 1'b1;
        ph = PH_ENTRY;
        phase = PH_ENTRY;
      end
      if (drp && ph != PH_ENTRY) begin
        if (count != CNT_MAX) count++;
        phase = PH_LOOP;
      end else if (!drp) begin
        phase = PH_FIRST;
      end
      pending.push_back({drp, drp});
      last_drop = drp;
    endfunction

    function void check_verdict(logic d, logic f);
      verdict_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual drop=%b fetch_another=%b",
                 $time, d, f);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (d !== want.drop) begin
        $display("%0t: drop mismatch, expected %b, actual %b", $time, want.drop, d);
        errors++;
      end
      if (f !== want.fetch) begin
        $display("%0t: fetch_another mismatch, expected %b, actual %b", $time, want.fetch, f);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic start_of_call = 1'b0;
  logic [TIME_W-1:0] current_time = '0;
  logic [TIME_W-1:0] arrival_stamp = '0;
  logic queue_empty_after = 1'b0;
  logic [BYTES_W-1:0] bytes_after = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic drop;
  logic fetch_another;

  bit no_idle = 1'b0;
  logic [TIME_W-1:0] clock_now = '0;
  codel_law_tracker tracker = new();

  codel_drop_controller #(.TIME_BITS(TIME_W)) dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .start_of_call     (start_of_call),
    .current_time      (current_time),
    .arrival_stamp     (arrival_stamp),
    .queue_empty_after (queue_empty_after),
    .bytes_after       (bytes_after),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .drop              (drop),
    .fetch_another     (fetch_another)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_pkt(input pkt_t p);
    int gap;
    in_valid          <= 1'b1;
    start_of_call     <= p.start;
    current_time      <= p.now;
    arrival_stamp     <= p.arr;
    queue_empty_after <= p.empty;
    bytes_after       <= p.bytes;
    do @(posedge clk); while (!in_ready);
    tracker.take_packet(p);
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, val);
  endtask

  task automatic configure(input logic [REG_W-1:0] t, input logic [REG_W-1:0] iv,
                           input logic [REG_W-1:0] b);
    write_reg(REG_TARGET_DELAY, t);
    write_reg(REG_DROP_INTERVAL, iv);
    write_reg(REG_ONE_PACKET_BYTES, b);
    write_reg(REG_UNUSED, REG_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_traffic(input int n, input int bad_pct);
    int sent;
    int k;
    logic [TIME_W-1:0] soj;
    pkt_t p;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) == 0) drain();
      if ($urandom_range(0, 9) == 0) begin
        p.start = $urandom_range(0, 1);
        p.now   = TIME_W'({$urandom, $urandom});
        p.arr   = TIME_W'({$urandom, $urandom});
        p.empty = $urandom_range(0, 1);
        p.bytes = BYTES_W'($urandom);
        send_pkt(p);
        sent++;
      end else begin
        clock_now += TIME_W'($urandom_range(0, int'(tracker.interval) / 3 + 2));
        k = 0;
        do begin
          p.start = (k == 0);
          if ($urandom_range(0, 14) == 0) p.start = !p.start;
          p.now = clock_now;
          if ($urandom_range(1, 100) <= bad_pct)
            soj = TIME_W'(tracker.target) +
                  TIME_W'($urandom_range(0, 2 * int'(tracker.target) + 3));
          else
            soj = TIME_W'($urandom_range(0, tracker.target));
          p.arr   = p.now - soj;
          p.empty = ($urandom_range(0, 24) == 0);
          if ($urandom_range(1, 100) <= bad_pct)
            p.bytes = BYTES_W'($urandom_range(int'(tracker.min_bytes) + 1, 24'hFFFFFF));
          else
            p.bytes = BYTES_W'($urandom_range(0, tracker.min_bytes));
          send_pkt(p);
          sent++;
          k++;
        end while (tracker.last_drop && k < 12);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_pkt({1'b1, 48'd0, 48'd0, 1'b1, 24'd0});
    send_pkt({1'b0, T_MAX, T_MAX, 1'b0, 24'hFFFFFF});
    send_pkt({1'b1, 48'd10, 48'd20, 1'b0, 24'hFFFFFF});
    send_pkt({1'b1, 48'd50, 48'd45, 1'b0, 24'd1504});
    send_pkt({1'b1, 48'd60, 48'd55, 1'b0, 24'd1505});
    send_pkt({1'b1, 48'd160, 48'd100, 1'b0, 24'd4000});
    send_pkt({1'b0, 48'd160, 48'd101, 1'b0, 24'd4000});
    send_pkt({1'b1, 48'd170, 48'd150, 1'b0, 24'd4000});
    send_pkt({1'b1, 48'd260, 48'd200, 1'b0, 24'd4000});
    send_pkt({1'b0, 48'd260, 48'd201, 1'b0, 24'd4000});
    send_pkt({1'b1, 48'd330, 48'd300, 1'b0, 24'd4000});
    send_pkt({1'b1, 48'd400, 48'd390, 1'b0, 24'd4000});
    send_pkt({1'b1, 48'd410, 48'd409, 1'b0, 24'd4000});
    send_pkt({1'b1, 48'hFFFF_FFFF_FF9C, 48'hFFFF_FFFF_FF90, 1'b0, 24'd9000});
    send_pkt({1'b1, 48'hFFFF_FFFF_FFA0, 48'hFFFF_FFFF_FF90, 1'b0, 24'd9000});
    send_pkt({1'b1, 48'hFFFF_FFFF_FFA1, 48'd0, 1'b0, 24'd9000});
    send_pkt({1'b0, 48'hFFFF_FFFF_FFA1, 48'd5, 1'b0, 24'd9000});
    drain();

    clock_now = TIME_W'({$urandom, $urandom});
    run_traffic(220, 80);
    drain();

    configure(16'd1, 16'd1, 16'd1);
    no_idle = 1'b1;
    run_traffic(180, 70);
    drain();

    configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
    no_idle = 1'b0;
    clock_now = T_MAX - TIME_W'($urandom_range(0, 1 << 20));
    run_traffic(200, 95);
    drain();

    configure(16'd0, 16'd0, 16'd0);
    run_traffic(150, 60);
    drain();

    configure(REG_W'($urandom_range(2, 40)), REG_W'($urandom_range(20, 400)), REG_W'($urandom));
    clock_now = TIME_W'({$urandom, $urandom});
    run_traffic(250, 85);
    drain();

    configure(REG_W'($urandom_range(2, 40)), REG_W'($urandom_range(20, 400)), REG_W'($urandom));
    no_idle = 1'b1;
    run_traffic(250, 75);
    no_idle = 1'b0;
    drain();

    if (tracker.errors == 0) begin
      $display("PASS codel_drop_controller");
    end else begin
      $display("FAIL codel_drop_controller");
    end
    $finish;
  end

  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        tracker.check_verdict(drop, fetch_another);
        stall = no_idle ? 0 : $urandom_range(0, 9);
        if (stall != 0) begin
          out_ready <= 1'b0;
          if ($urandom_range(0, 1)) begin
            do @(posedge clk); while (!out_valid);
            repeat (stall - 1) @(posedge clk);
          end else begin
            repeat (stall) @(posedge clk);
          end
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL codel_drop_controller");
    $finish;
  end

endmodule

// File: files.f
design/codel_pkg.sv
design/codel_drop_controller.sv
tb/codel_drop_controller_tb.sv
